@@ hw/rtl/pfx_pkg.sv @@
// shared constants and types of the postfix expression evaluator
// no dependencies; imported by pfx_ram users, pfx_div and the top level
`default_nettype none

package pfx_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int CNT_W       = $clog2(DATA_W);
  localparam int SYM_W       = 8;
  localparam int DEPTH_W     = 6;
  localparam int OUT_W       = 48;

  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(STACK_DEPTH);

  // character codes
  localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_SLASH = 8'h2F;

  // request to the divider
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/pfx_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module pfx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/pfx_div.sv @@
// signed 32-bit divider, truncating toward zero, one quotient bit per cycle
// depends on pfx_pkg; divisor must be nonzero
`default_nettype none

module pfx_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire pfx_pkg::div_req_t        req,
  output logic                          done,
  output logic [pfx_pkg::DATA_W-1:0]    quotient
);
  import pfx_pkg::*;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic              neg;
  logic [DATA_W-1:0] dvd;
  logic [DATA_W-1:0] dvs;
  logic [DATA_W:0]   rem;
  logic [DATA_W:0]   trial;
  logic              qbit;
  logic [DATA_W:0]   rem_next;
  logic [DATA_W-1:0] q_next;

  always_comb begin
    trial    = {rem[DATA_W-1:0], dvd[DATA_W-1]};
    qbit     = (trial >= {1'b0, dvs});
    rem_next = qbit ? (trial - {1'b0, dvs}) : trial;
    q_next   = {dvd[DATA_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
        dvd  <= req.dividend[DATA_W-1] ? (DATA_W'(0) - req.dividend) : req.dividend;
        dvs  <= req.divisor[DATA_W-1] ? (DATA_W'(0) - req.divisor) : req.divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= q_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy     <= 1'b0;
          done     <= 1'b1;
          quotient <= neg ? (DATA_W'(0) - q_next) : q_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/postfix_expression_evaluator_unit.sv @@
// postfix evaluator: operand stack in a ram, one character per input transfer
// steps: digit pushed on transfer; + - * via op and writeback; / also waits on the divider; last then emits
// throughput: one character at a time, divide bound by the bit-serial divider
// reset clears stack pointer, flags and handshake state; the ram is not cleared
// depends on pfx_pkg, pfx_ram, pfx_div
`default_nettype none

module postfix_expression_evaluator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] symbol
  input  wire logic        s_tlast,   // last character of the expression
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata    // [31:0] value, [37:32] depth_left, [38] underflow,
                                      // [39] overflow, [40] div_zero, [41] empty_at_end
);
  import pfx_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OP   = 3'd1;  // ram read data of first operand valid
  localparam logic [2:0] ST_DIV  = 3'd2;  // waiting on the divider
  localparam logic [2:0] ST_WB   = 3'd3;  // push the operator result
  localparam logic [2:0] ST_EMIT = 3'd4;  // load the result register

  logic [2:0]        state;
  logic [PTR_W-1:0]  sp;          // entries held
  logic [DATA_W-1:0] top;         // copy of the top entry, also the second operand
  logic              flag_under;
  logic              flag_over;
  logic              flag_div0;
  logic [SYM_W-1:0]  sym_q;
  logic              last_q;
  logic [DATA_W-1:0] second_q;
  logic              first_ok;    // first operand comes from the ram
  logic [PTR_W-1:0]  base_sp;     // pointer after both pops
  logic [DATA_W-1:0] result;

  logic              accept;
  logic              is_op;
  logic [DATA_W-1:0] digit_val;
  logic [DATA_W-1:0] first;
  logic              out_free;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  div_req_t          div_req;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign is_op     = (s_tdata == SYM_PLUS) || (s_tdata == SYM_MINUS) ||
                     (s_tdata == SYM_STAR) || (s_tdata == SYM_SLASH);
  assign digit_val = DATA_W'(s_tdata) - DATA_W'(SYM_ZERO);
  assign first     = first_ok ? ram_rdata : '1;
  assign out_free  = !m_tvalid || m_tready;

  // the first operand sits one below the top; its read goes out with the transfer
  assign ram_raddr = ADDR_W'(sp - PTR_W'(2));

  // single write port: digit push on transfer, operator result in writeback
  always_comb begin
    if (state == ST_WB) begin
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(base_sp);
      ram_wdata = result;
    end else begin
      ram_we    = accept && !is_op && (sp < DEPTH_P);
      ram_waddr = ADDR_W'(sp);
      ram_wdata = digit_val;
    end
  end

  // divide by zero never reaches the divider
  always_comb begin
    div_req.start    = (state == ST_OP) && (sym_q == SYM_SLASH) && (second_q != '0);
    div_req.dividend = first;
    div_req.divisor  = second_q;
  end

  pfx_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      sp         <= '0;
      flag_under <= 1'b0;
      flag_over  <= 1'b0;
      flag_div0  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // the emit state reloads the result register on its own
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            sym_q  <= s_tdata;
            last_q <= s_tlast;
            if (is_op) begin
              // pop second from the cached top, first from the ram
              second_q <= (sp == '0) ? '1 : top;
              first_ok <= (sp >= PTR_W'(2));
              base_sp  <= (sp >= PTR_W'(2)) ? (sp - PTR_W'(2)) : '0;
              if (sp < PTR_W'(2)) begin
                flag_under <= 1'b1;
              end
              state <= ST_OP;
            end else begin
              if (sp < DEPTH_P) begin
                sp  <= sp + 1'b1;
                top <= digit_val;
              end else begin
                flag_over <= 1'b1;
              end
              state <= s_tlast ? ST_EMIT : ST_IDLE;
            end
          end
        end
        ST_OP: begin
          case (sym_q)
            SYM_PLUS: begin
              result <= first + second_q;
              state  <= ST_WB;
            end
            SYM_MINUS: begin
              result <= first - second_q;
              state  <= ST_WB;
            end
            SYM_STAR: begin
              result <= first * second_q;
              state  <= ST_WB;
            end
            default: begin
              if (second_q == '0) begin
                result    <= '0;
                flag_div0 <= 1'b1;
                state     <= ST_WB;
              end else begin
                state <= ST_DIV;
              end
            end
          endcase
        end
        ST_DIV: begin
          if (div_done) begin
            result <= div_quo;
            state  <= ST_WB;
          end
        end
        ST_WB: begin
          // two pops leave room, so this push always lands
          sp    <= base_sp + 1'b1;
          top   <= result;
          state <= last_q ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid          <= 1'b1;
            m_tdata[31:0]     <= (sp == '0) ? '0 : top;
            m_tdata[37:32]    <= DEPTH_W'(sp);
            m_tdata[38]       <= flag_under;
            m_tdata[39]       <= flag_over;
            m_tdata[40]       <= flag_div0;
            m_tdata[41]       <= (sp == '0);
            m_tdata[47:42]    <= '0;
            // expression done: empty the stack, clear sticky flags
            sp         <= '0;
            flag_under <= 1'b0;
            flag_over  <= 1'b0;
            flag_div0  <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // stack pointer never passes the depth
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= DEPTH_P)
    else $error("stack pointer beyond depth");

  // emitting a result empties the stack and clears the flags
  a_emit_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free) |=>
      (sp == '0 && !flag_under && !flag_over && !flag_div0 && m_tvalid))
    else $error("stack not cleared after result");

  // divider only started with a nonzero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> (div_req.divisor != '0))
    else $error("divider started with zero divisor");

  // empty stack reports value zero and depth zero
  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[41]) |-> (m_tdata[31:0] == '0 && m_tdata[37:32] == '0))
    else $error("empty stack with nonzero value or depth");

  // no input transfer while an item is in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready)
    else $error("input taken during processing");

endmodule

`default_nettype wire
